// ===== rtl/mft_pkg.sv =====
// shared types, constants and modular arithmetic for the modular fenwick tree unit
`default_nettype none

package mft_pkg;

	localparam int unsigned VAL_W  = 30;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned CMD_W  = 2;

	localparam logic [VAL_W-1:0]  MODULUS    = 30'd998244353;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SUM   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] last_index;
		logic [VAL_W-1:0] delta;
	} mft_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] range_total;
		logic             index_error;
	} mft_rsp_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic sel_lo;
	} mft_acc_ctl_t;

	function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODULUS}) begin
			return VAL_W'(s - {1'b0, MODULUS});
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		if (a >= b) begin
			return a - b;
		end
		return VAL_W'(({1'b0, a} + {1'b0, MODULUS}) - {1'b0, b});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mft_accum.sv =====
// prefix accumulators for the upper and lower chain and the final modular difference
`default_nettype none

module mft_accum
	import mft_pkg::*;
(
	input  wire logic         clk,
	input  mft_acc_ctl_t      ctl,
	input  wire logic [29:0]  rdata,
	output logic [29:0]       total
);

	logic [VAL_W-1:0] acc_hi_q;
	logic [VAL_W-1:0] acc_lo_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_hi_q <= '0;
			acc_lo_q <= '0;
		end else if (ctl.en) begin
			if (ctl.sel_lo) begin
				acc_lo_q <= mod_add(acc_lo_q, rdata);
			end else begin
				acc_hi_q <= mod_add(acc_hi_q, rdata);
			end
		end
	end

	assign total = mod_sub(acc_hi_q, acc_lo_q);

endmodule

`default_nettype wire

// ===== rtl/modular_fenwick_tree_unit.sv =====
// top level: command sequencer, tree memory and size register of the modular fenwick tree
// add: a read state and a write state per tree entry on the upward chain, then the done strobe
// range sum: one memory read a cycle over both prefix chains, then S_FIN and S_DONE
// clear and errors: clear sweeps DEPTH entries, one per cycle; an error goes straight to S_DONE
// reset runs a clearing sweep of all DEPTH memory entries with busy high; size resets to 1024
// one command at a time; results appear as a one-cycle done strobe with no backpressure
`default_nettype none

module modular_fenwick_tree_unit
	import mft_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  mft_req_t         req,
	output logic             done,
	output mft_rsp_t         rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = ($clog2(DEPTH + 1) > SIZE_W) ? $clog2(DEPTH + 1) : SIZE_W;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CLR    = 8'b0000_0010,
		S_ADD_RD = 8'b0000_0100,
		S_ADD_WR = 8'b0000_1000,
		S_HI     = 8'b0001_0000,
		S_LO     = 8'b0010_0000,
		S_FIN    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} mft_state_t;

	mft_state_t        st_q;
	logic [SIZE_W-1:0] size_q;
	logic [AW-1:0]     clr_q;
	logic              clr_cmd_q;
	logic [NW-1:0]     idx_q;
	logic [NW-1:0]     pos_q;
	logic [IDX_W-1:0]  first_q;
	logic [VAL_W-1:0]  delta_q;
	logic              err_q;
	logic              rd_v_s1;
	logic              sel_s1;
	logic              done_q;
	mft_rsp_t          rsp_q;

	logic [VAL_W-1:0]  mem [DEPTH];
	logic [VAL_W-1:0]  rdata_q;
	logic              we;
	logic [AW-1:0]     wa;
	logic [VAL_W-1:0]  wd;
	logic              re;
	logic [AW-1:0]     ra;

	logic [NW-1:0]     n_eff;
	logic [NW-1:0]     size_ext;
	logic [NW-1:0]     first_ext;
	logic [NW-1:0]     last_ext;
	logic [NW-1:0]     r_pos;
	logic [NW-1:0]     pos_nxt;
	logic [NW-1:0]     idx_nxt;
	logic [VAL_W-1:0]  delta_red;
	logic              accept;
	mft_acc_ctl_t      acc_ctl;
	logic [VAL_W-1:0]  total;

	assign accept    = start && !busy;
	assign busy      = (st_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign size_ext  = NW'(size_q);
	assign n_eff     = (size_ext > NW'(DEPTH)) ? NW'(DEPTH) : size_ext;
	assign first_ext = NW'(req.first_index);
	assign last_ext  = NW'(req.last_index);
	assign r_pos     = pos_q - NW'(1);
	assign pos_nxt   = r_pos & (r_pos + NW'(1));
	assign idx_nxt   = idx_q | (idx_q + NW'(1));
	assign delta_red = (req.delta >= MODULUS) ? (req.delta - MODULUS) : req.delta;

	// memory ports
	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		re = 1'b0;
		ra = idx_q[AW-1:0];
		unique case (st_q)
			S_CLR: begin
				we = 1'b1;
			end
			S_ADD_RD: begin
				re = 1'b1;
			end
			S_ADD_WR: begin
				we = 1'b1;
				wa = idx_q[AW-1:0];
				wd = mod_add(rdata_q, delta_q);
			end
			S_HI, S_LO: begin
				re = 1'b1;
				ra = r_pos[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= req.first_index;
			delta_q <= delta_red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLR;
			clr_q     <= '0;
			clr_cmd_q <= 1'b0;
			idx_q     <= '0;
			pos_q     <= '0;
			err_q     <= 1'b0;
			rd_v_s1   <= 1'b0;
			sel_s1    <= 1'b0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
		end else begin
			done_q  <= 1'b0;
			rd_v_s1 <= (st_q == S_HI) || (st_q == S_LO);
			sel_s1  <= (st_q == S_LO);
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						err_q <= 1'b0;
						st_q  <= S_DONE;
						unique case (req.command)
							CMD_ADD: begin
								if (first_ext >= n_eff) begin
									err_q <= 1'b1;
								end else begin
									idx_q <= first_ext;
									st_q  <= S_ADD_RD;
								end
							end
							CMD_SUM: begin
								if (first_ext >= n_eff || last_ext >= n_eff) begin
									err_q <= 1'b1;
								end else if (first_ext <= last_ext) begin
									pos_q <= last_ext + NW'(1);
									st_q  <= S_HI;
								end
							end
							CMD_CLEAR: begin
								clr_q     <= '0;
								clr_cmd_q <= 1'b1;
								st_q      <= S_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						st_q <= clr_cmd_q ? S_DONE : S_IDLE;
					end
				end
				S_ADD_RD: begin
					st_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					idx_q <= idx_nxt;
					st_q  <= (idx_nxt < n_eff) ? S_ADD_RD : S_DONE;
				end
				S_HI: begin
					pos_q <= pos_nxt;
					if (pos_nxt == '0) begin
						if (first_q != '0) begin
							pos_q <= NW'(first_q);
							st_q  <= S_LO;
						end else begin
							st_q <= S_FIN;
						end
					end
				end
				S_LO: begin
					pos_q <= pos_nxt;
					if (pos_nxt == '0) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					done_q            <= 1'b1;
					rsp_q.range_total <= total;
					rsp_q.index_error <= err_q;
					clr_cmd_q         <= 1'b0;
					st_q              <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign acc_ctl.clr    = accept;
	assign acc_ctl.en     = rd_v_s1;
	assign acc_ctl.sel_lo = sel_s1;

	mft_accum u_accum (
		.clk   (clk),
		.ctl   (acc_ctl),
		.rdata (rdata_q),
		.total (total)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a command");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.index_error) |-> (rsp.range_total == '0))
		else $error("index error with nonzero total");

	a_add_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ADD_WR) |-> (idx_q < n_eff))
		else $error("add walk beyond size in use");

	a_chain_live: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_HI || st_q == S_LO) |-> (pos_q != '0))
		else $error("prefix walk with empty position count");

endmodule

`default_nettype wire

// ===== sim/mft_checker.sv =====
`timescale 1ns / 1ps
// checker for the modular fenwick tree unit: tracks the tree, predicts each response, compares
module mft_checker
	import mft_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  mft_req_t               req,
	input  wire logic              done,
	input  mft_rsp_t               rsp,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     checked_count,
	output int                     flagged_count
);

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned PRIME = 998244353;

	logic [VAL_W-1:0]  tree_sums [DEPTH];
	logic [SIZE_W-1:0] size_reg;
	mft_rsp_t          expected_rsp [$];
	mft_rsp_t          oldest;

	function automatic int unsigned wrap_sum(input int unsigned a, input int unsigned b);
		int unsigned s;
		s = a + b;
		return (s >= PRIME) ? s - PRIME : s;
	endfunction

	// sum of positions 0..top
	function automatic int unsigned prefix_through(input int unsigned top);
		int unsigned acc;
		int unsigned span;
		acc = 0;
		span = top + 1;
		while (span > 0) begin
			acc = wrap_sum(acc, tree_sums[span-1]);
			span = (span - 1) & span;
		end
		return acc;
	endfunction

	function automatic mft_rsp_t apply_command(input mft_req_t c);
		mft_rsp_t    r;
		int unsigned n;
		int unsigned pos;
		int unsigned amount;
		int unsigned hi;
		int unsigned lo;
		r = '0;
		n = (size_reg > DEPTH) ? DEPTH : size_reg;
		amount = c.delta % PRIME;
		case (c.command)
			CMD_ADD: begin
				if (c.first_index >= n) begin
					r.index_error = 1'b1;
				end else begin
					pos = c.first_index;
					while (pos < n) begin
						tree_sums[pos] = VAL_W'(wrap_sum(tree_sums[pos], amount));
						pos = pos | (pos + 1);
					end
				end
			end
			CMD_SUM: begin
				if (c.first_index >= n || c.last_index >= n) begin
					r.index_error = 1'b1;
				end else if (c.first_index <= c.last_index) begin
					hi = prefix_through(c.last_index);
					lo = (c.first_index == 0) ? 0 : prefix_through(c.first_index - 1);
					r.range_total = VAL_W'((hi >= lo) ? hi - lo : hi + PRIME - lo);
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) begin
					tree_sums[i] = '0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tree_sums[i] = '0;
			end
			size_reg = SIZE_RESET;
			expected_rsp.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected response: total %0d err %0b",
							rsp.range_total, rsp.index_error);
					end
				end else begin
					oldest = expected_rsp.pop_front();
					checked_count++;
					if (rsp.index_error === 1'b1) begin
						flagged_count++;
					end
					if (rsp.range_total !== oldest.range_total ||
							rsp.index_error !== oldest.index_error) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch on response %0d: expected total %0d err %0b",
								checked_count, oldest.range_total, oldest.index_error);
							$display("  got total %0d err %0b",
								rsp.range_total, rsp.index_error);
						end
					end
				end
			end
			if (start && !busy) begin
				expected_rsp.insert(expected_rsp.size(), apply_command(req));
			end
			if (cfg_valid && cfg_ready) begin
				size_reg = cfg_data;
			end
			pending <= expected_rsp.size();
		end
	end

endmodule

// ===== sim/modular_fenwick_tree_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the modular fenwick tree unit: stimulus, size settings and verdict
module modular_fenwick_tree_unit_tb;
	import mft_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
	localparam logic [VAL_W-1:0] DELTA_ONES    = '1;
	localparam logic [VAL_W-1:0] DELTA_TOP     = MODULUS - 30'd1;
	localparam logic [IDX_W-1:0] IDX_TOP       = '1;
	localparam int               PHASE_ITEMS   = 120;
	localparam int               PLAN_LEN      = 12;
	localparam int               CYCLE_LIMIT   = 600000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	mft_req_t          req;
	logic              done;
	mft_rsp_t          rsp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int checked_count;
	int flagged_count;
	int cycle_count;
	int issued_count;
	int add_count;
	int sum_count;
	int clear_count;
	int setting_count;

	logic [SIZE_W-1:0] size_plan [PLAN_LEN] = '{11'd1, 11'd2, 11'd3, 11'd16, 11'd37,
		11'd512, 11'd1023, 11'd0, 11'd2047, 11'd1025, 11'd1024, 11'd1024};

	modular_fenwick_tree_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	mft_checker response_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.flagged_count (flagged_count)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	// returns at the edge where the command transfer happens
	task automatic issue(input mft_req_t r);
		start <= 1'b1;
		req <= r;
		issued_count++;
		case (r.command)
			CMD_ADD:   add_count++;
			CMD_SUM:   sum_count++;
			CMD_CLEAR: clear_count++;
			default: begin
			end
		endcase
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic pause_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0 || busy);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	// mostly in range, now and then anywhere in the index field
	function automatic logic [IDX_W-1:0] pick_index(input int unsigned n);
		if (n > 0 && $urandom_range(0, 9) != 0) begin
			return IDX_W'($urandom_range(0, n - 1));
		end
		return IDX_W'($urandom_range(0, 1023));
	endfunction

	function automatic mft_req_t random_request(input int unsigned n);
		mft_req_t         r;
		int unsigned      pick;
		logic [IDX_W-1:0] swap;
		r.first_index = pick_index(n);
		r.last_index = pick_index(n);
		case ($urandom_range(0, 9))
			0:       r.delta = DELTA_TOP - VAL_W'($urandom_range(0, 3));
			1:       r.delta = VAL_W'($urandom());
			2:       r.delta = VAL_W'($urandom_range(0, 15));
			default: r.delta = VAL_W'($urandom_range(0, MODULUS - 1));
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.command = CMD_ADD;
		end else if (pick < 94) begin
			r.command = CMD_SUM;
			if (r.first_index > r.last_index && $urandom_range(0, 5) != 0) begin
				swap = r.first_index;
				r.first_index = r.last_index;
				r.last_index = swap;
			end
		end else if (pick < 96) begin
			r.command = CMD_CLEAR;
		end else begin
			r.command = CMD_UNUSED;
		end
		return r;
	endfunction

	initial begin
		logic [SIZE_W-1:0] size_now;
		int unsigned       active_n;
		int                sent;
		int                burst;
		start <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// full size after reset
		issue(mft_req_t'{CMD_ADD, 10'd0, 10'd0, 30'd0});
		issue(mft_req_t'{CMD_ADD, 10'd0, 10'd0, DELTA_TOP});
		issue(mft_req_t'{CMD_ADD, IDX_TOP, 10'd0, DELTA_ONES});
		issue(mft_req_t'{CMD_ADD, 10'd511, 10'd0, MODULUS});
		issue(mft_req_t'{CMD_ADD, 10'd1022, 10'd0, 30'd12345});
		issue(mft_req_t'{CMD_SUM, 10'd0, IDX_TOP, 30'd0});
		issue(mft_req_t'{CMD_SUM, 10'd0, 10'd0, 30'd0});
		issue(mft_req_t'{CMD_SUM, IDX_TOP, IDX_TOP, 30'd0});
		issue(mft_req_t'{CMD_SUM, 10'd600, 10'd100, 30'd0});
		issue(mft_req_t'{CMD_SUM, 10'd1, 10'd1022, 30'd0});
		issue(mft_req_t'{CMD_UNUSED, IDX_TOP, IDX_TOP, DELTA_ONES});
		issue(mft_req_t'{CMD_CLEAR, 10'd0, 10'd0, 30'd0});
		issue(mft_req_t'{CMD_SUM, 10'd0, IDX_TOP, 30'd0});

		for (int p = 0; p < PLAN_LEN; p++) begin
			size_now = (p == PLAN_LEN - 1) ? SIZE_W'($urandom_range(1, 1024)) : size_plan[p];
			write_size(size_now);
			active_n = (size_now > 1024) ? 1024 : size_now;
			if (size_now == 11'd1) begin
				issue(mft_req_t'{CMD_ADD, 10'd0, 10'd0, 30'd7});
				issue(mft_req_t'{CMD_ADD, 10'd1, 10'd0, 30'd5});
				issue(mft_req_t'{CMD_SUM, 10'd0, 10'd0, 30'd0});
				issue(mft_req_t'{CMD_SUM, 10'd1, 10'd0, 30'd0});
				issue(mft_req_t'{CMD_SUM, 10'd0, IDX_TOP, 30'd0});
			end else if (size_now == 11'd0) begin
				issue(mft_req_t'{CMD_ADD, 10'd0, 10'd0, 30'd3});
				issue(mft_req_t'{CMD_SUM, 10'd0, 10'd0, 30'd0});
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 20);
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					issue(random_request(active_n));
					sent++;
				end
				case ($urandom_range(0, 9))
					0:       drain();
					1, 2, 3: begin
					end
					default: pause_for($urandom_range(1, 12));
				endcase
			end
		end

		drain();
		repeat (30) @(posedge clk);
		$display("sent %0d commands (%0d point adds, %0d range sums, %0d clears) over %0d size settings",
			issued_count, add_count, sum_count, clear_count, setting_count);
		$display("compared %0d responses, %0d of them flagged as index errors",
			checked_count, flagged_count);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== modular_fenwick_tree_unit.f =====
rtl/mft_pkg.sv
rtl/mft_accum.sv
rtl/modular_fenwick_tree_unit.sv
sim/mft_checker.sv
sim/modular_fenwick_tree_unit_tb.sv
